// File: hw/rtl/oneshot_periodic_timer_bank_unit_defines.svh
// Assertion macros shared by the timer bank RTL.
`ifndef ONESHOT_PERIODIC_TIMER_BANK_UNIT_DEFINES_SVH
`define ONESHOT_PERIODIC_TIMER_BANK_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define OPTB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define OPTB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/optb_pkg.sv
// Shared constants and types of the timer bank.
`default_nettype none

package optb_pkg;

    localparam int NUM_TIMERS = 8;
    localparam int IDX_W      = 3;
    localparam int CNT_W      = IDX_W + 1;
    localparam int TIME_W     = 32;
    localparam int CMD_W      = 3;
    localparam int KIND_W     = 2;

    localparam logic [CMD_W-1:0] CMD_CHECK   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ARM_ONE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ARM_PER = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RESTART = 3'd3;
    localparam logic [CMD_W-1:0] CMD_STOP    = 3'd4;

    localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FIRED  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd2;

    // Write request from the sequencer into the slot store.
    typedef struct packed {
        logic              arm;
        logic              reload;
        logic              halt;
        logic [IDX_W-1:0]  idx;
        logic [TIME_W-1:0] period;
        logic              periodic;
        logic              notify;
        logic [TIME_W-1:0] now;
    } slot_wr_t;

    // State of the slot under the shared compare unit.
    typedef struct packed {
        logic running;
        logic notify;
        logic periodic;
        logic expired;
    } slot_rd_t;

endpackage

`default_nettype wire

// File: hw/rtl/optb_slots.sv
// Timer slot store with the shared elapsed-time subtract and compare unit.
`default_nettype none

module optb_slots
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [optb_pkg::IDX_W-1:0]      rd_idx,
    input  wire logic [optb_pkg::TIME_W-1:0]     now,
    input  wire optb_pkg::slot_wr_t              wr,
    output optb_pkg::slot_rd_t                   rd,
    output logic [optb_pkg::NUM_TIMERS-1:0]      running_mask
);

    logic [optb_pkg::TIME_W-1:0]     start_reg  [optb_pkg::NUM_TIMERS];
    logic [optb_pkg::TIME_W-1:0]     period_reg [optb_pkg::NUM_TIMERS];
    logic [optb_pkg::NUM_TIMERS-1:0] running_reg;
    logic [optb_pkg::NUM_TIMERS-1:0] periodic_reg;
    logic [optb_pkg::NUM_TIMERS-1:0] notify_reg;
    logic [optb_pkg::TIME_W-1:0]     elapsed;

    // Wrapping elapsed time of the selected slot.
    assign elapsed     = now - start_reg[rd_idx];
    assign rd.expired  = (elapsed >= period_reg[rd_idx]);
    assign rd.running  = running_reg[rd_idx];
    assign rd.notify   = notify_reg[rd_idx];
    assign rd.periodic = periodic_reg[rd_idx];

    assign running_mask = running_reg;

    always_ff @(posedge clk)
    begin
        if (wr.arm)
        begin
            start_reg[wr.idx]  <= wr.now;
            period_reg[wr.idx] <= wr.period;
        end
        else if (wr.reload)
        begin
            start_reg[wr.idx] <= wr.now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg  <= '0;
            periodic_reg <= '0;
            notify_reg   <= '0;
        end
        else if (wr.arm)
        begin
            running_reg[wr.idx]  <= 1'b1;
            periodic_reg[wr.idx] <= wr.periodic;
            notify_reg[wr.idx]   <= wr.notify;
        end
        else if (wr.halt)
        begin
            running_reg[wr.idx]  <= 1'b0;
            periodic_reg[wr.idx] <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/optb_ctrl.sv
// Command sequencer: walks the slots for a check and issues result beats.
`default_nettype none

module optb_ctrl
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [optb_pkg::CMD_W-1:0]        in_command,
    input  wire logic [optb_pkg::IDX_W-1:0]        in_index,
    input  wire logic [optb_pkg::TIME_W-1:0]       in_interval,
    input  wire logic                              in_notify,
    input  wire logic [optb_pkg::TIME_W-1:0]       in_now,
    input  wire logic [optb_pkg::CNT_W-1:0]        lim,
    output logic [optb_pkg::IDX_W-1:0]             rd_idx,
    output logic [optb_pkg::TIME_W-1:0]            now,
    input  wire optb_pkg::slot_rd_t                rd,
    output optb_pkg::slot_wr_t                     wr,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [optb_pkg::KIND_W-1:0]            out_kind,
    output logic                                   out_ok,
    output logic [optb_pkg::IDX_W-1:0]             out_index,
    output logic                                   out_last
);

    localparam logic [2:0] ST_IDLE       = 3'd0;
    localparam logic [2:0] ST_WALK       = 3'd1;
    localparam logic [2:0] ST_EXEC       = 3'd2;
    localparam logic [2:0] ST_SEND_ONE   = 3'd3;
    localparam logic [2:0] ST_SEND_FIRED = 3'd4;

    logic [2:0]                      state_reg,    state_next;
    logic [optb_pkg::CMD_W-1:0]      cmd_reg,      cmd_next;
    logic [optb_pkg::IDX_W-1:0]      idx_reg,      idx_next;
    logic [optb_pkg::TIME_W-1:0]     interval_reg, interval_next;
    logic                            notify_reg,   notify_next;
    logic [optb_pkg::TIME_W-1:0]     now_reg,      now_next;
    logic [optb_pkg::CNT_W-1:0]      slot_reg,     slot_next;
    logic [optb_pkg::NUM_TIMERS-1:0] fired_reg,    fired_next;
    logic [optb_pkg::KIND_W-1:0]     kind_reg,     kind_next;
    logic                            ok_reg,       ok_next;
    logic [optb_pkg::IDX_W-1:0]      low_idx;
    logic                            fired_last;

    // Lowest pending fired slot.
    always_comb
    begin
        low_idx = '0;
        for (int i = optb_pkg::NUM_TIMERS - 1; i >= 0; i--)
        begin
            if (fired_reg[i])
            begin
                low_idx = optb_pkg::IDX_W'(i);
            end
        end
    end

    assign fired_last = ((fired_reg & (fired_reg - 1'b1)) == '0);

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_SEND_ONE) || (state_reg == ST_SEND_FIRED);
    assign out_kind  = (state_reg == ST_SEND_FIRED) ? optb_pkg::KIND_FIRED : kind_reg;
    assign out_ok    = (state_reg == ST_SEND_FIRED) ? 1'b1 : ok_reg;
    assign out_index = (state_reg == ST_SEND_FIRED) ? low_idx : idx_reg;
    assign out_last  = (state_reg == ST_SEND_FIRED) ? fired_last : 1'b1;

    assign rd_idx = (state_reg == ST_WALK) ? slot_reg[optb_pkg::IDX_W-1:0] : idx_reg;
    assign now    = now_reg;

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        idx_next      = idx_reg;
        interval_next = interval_reg;
        notify_next   = notify_reg;
        now_next      = now_reg;
        slot_next     = slot_reg;
        fired_next    = fired_reg;
        kind_next     = kind_reg;
        ok_next       = ok_reg;

        wr          = '0;
        wr.idx      = rd_idx;
        wr.period   = interval_reg;
        wr.periodic = (cmd_reg == optb_pkg::CMD_ARM_PER);
        wr.notify   = notify_reg;
        wr.now      = now_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next      = in_command;
                    idx_next      = in_index;
                    interval_next = in_interval;
                    notify_next   = in_notify;
                    now_next      = in_now;
                    slot_next     = '0;
                    fired_next    = '0;
                    state_next    = (in_command == optb_pkg::CMD_CHECK) ? ST_WALK : ST_EXEC;
                end
            end

            ST_WALK:
            begin
                if (slot_reg >= lim)
                begin
                    if (fired_reg == '0)
                    begin
                        kind_next  = optb_pkg::KIND_NONE;
                        ok_next    = 1'b1;
                        idx_next   = '0;
                        state_next = ST_SEND_ONE;
                    end
                    else
                    begin
                        state_next = ST_SEND_FIRED;
                    end
                end
                else
                begin
                    if (rd.running && rd.expired)
                    begin
                        // Periodic slots reload their start, one-shots halt.
                        wr.reload = rd.periodic;
                        wr.halt   = !rd.periodic;
                        if (rd.notify)
                        begin
                            fired_next[slot_reg[optb_pkg::IDX_W-1:0]] = 1'b1;
                        end
                    end
                    slot_next = slot_reg + 1'b1;
                end
            end

            ST_EXEC:
            begin
                kind_next  = optb_pkg::KIND_STATUS;
                state_next = ST_SEND_ONE;
                case (cmd_reg)
                    optb_pkg::CMD_ARM_ONE, optb_pkg::CMD_ARM_PER:
                    begin
                        ok_next = ({1'b0, idx_reg} < lim) && !rd.running;
                        wr.arm  = ok_next;
                    end
                    optb_pkg::CMD_RESTART:
                    begin
                        ok_next   = rd.running && !rd.expired;
                        wr.reload = ok_next;
                    end
                    optb_pkg::CMD_STOP:
                    begin
                        ok_next = 1'b1;
                        wr.halt = 1'b1;
                    end
                    default:
                    begin
                        ok_next = 1'b0;
                    end
                endcase
            end

            ST_SEND_ONE:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_SEND_FIRED:
            begin
                if (out_ready)
                begin
                    // Drop the slot just sent.
                    fired_next[low_idx] = 1'b0;
                    if (fired_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            slot_reg  <= '0;
            fired_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            fired_reg <= fired_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        idx_reg      <= idx_next;
        interval_reg <= interval_next;
        notify_reg   <= notify_next;
        now_reg      <= now_next;
        kind_reg     <= kind_next;
        ok_reg       <= ok_next;
    end

endmodule

`default_nettype wire

// File: hw/rtl/oneshot_periodic_timer_bank_unit.sv
// A bank of eight millisecond timers, driven by one command per input beat.
// Each input beat carries the current time and one command: check the timers in use, arm one-shot,
// arm periodic, restart or stop. The block takes one beat at a time and drops s_tready until
// every result beat of that command has been taken. A single shared subtract-and-compare unit
// reads one slot per cycle, so a check walks every slot in use and then sends its result beats;
// any other command is executed on its slot and answered with one status beat. All result
// beats of a check report the running mask as it stands after the whole check. The user must
// write timers_in_use through cfg_wr_en/cfg_wr_data only while the block is idle; the block
// itself does not enforce it. Values above eight saturate to eight.
`default_nettype none
`include "oneshot_periodic_timer_bank_unit_defines.svh"

module oneshot_periodic_timer_bank_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // timer_index, interval_ms, notify, now_ms, zero pad
    input  wire logic [2:0]  s_tuser,   // command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // ok, fired_index, running_mask, zero pad
    output logic [1:0]       m_tuser,   // kind
    output logic             m_tlast,
    input  wire logic        cfg_wr_en,
    input  wire logic [3:0]  cfg_wr_data
);

    logic [optb_pkg::CNT_W-1:0]      tiu_reg;
    logic [optb_pkg::CNT_W-1:0]      lim;
    logic [optb_pkg::IDX_W-1:0]      rd_idx;
    logic [optb_pkg::TIME_W-1:0]     now;
    optb_pkg::slot_rd_t              rd;
    optb_pkg::slot_wr_t              wr;
    logic [optb_pkg::NUM_TIMERS-1:0] running_mask;
    logic                            out_ok;
    logic [optb_pkg::IDX_W-1:0]      out_index;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tiu_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            tiu_reg <= cfg_wr_data;
        end
    end

    assign lim = (tiu_reg > optb_pkg::CNT_W'(optb_pkg::NUM_TIMERS)) ?
                 optb_pkg::CNT_W'(optb_pkg::NUM_TIMERS) : tiu_reg;

    optb_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_command  (s_tuser),
        .in_index    (s_tdata[2:0]),
        .in_interval (s_tdata[34:3]),
        .in_notify   (s_tdata[35]),
        .in_now      (s_tdata[67:36]),
        .lim         (lim),
        .rd_idx      (rd_idx),
        .now         (now),
        .rd          (rd),
        .wr          (wr),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_kind    (m_tuser),
        .out_ok      (out_ok),
        .out_index   (out_index),
        .out_last    (m_tlast)
    );

    optb_slots u_slots
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .rd_idx       (rd_idx),
        .now          (now),
        .wr           (wr),
        .rd           (rd),
        .running_mask (running_mask)
    );

    assign m_tdata = {4'b0000, running_mask, out_index, out_ok};

    `OPTB_ASSERT_IMP(a_one_side_busy, m_tvalid, !s_tready, "input taken while results pending")
    `OPTB_ASSERT_IMP(a_fired_in_use, m_tvalid && (m_tuser == optb_pkg::KIND_FIRED),
        {1'b0, m_tdata[3:1]} < lim, "fired beat for a slot not in use")
    `OPTB_ASSERT_IMP(a_none_is_last, m_tvalid && (m_tuser == optb_pkg::KIND_NONE),
        m_tlast && (m_tdata[3:1] == 3'd0), "nothing-found beat malformed")
    `OPTB_ASSERT_NEXT(a_last_frees, m_tvalid && m_tready && m_tlast, s_tready,
        "block not idle after final beat")

endmodule

`default_nettype wire
